### design/lkc_pkg.sv
// Shared types and constants for the LRU key cache lookup block.
// Used by the controller, the datapath and the top level; no dependencies.
package lkc_pkg;

  // Field widths fixed by the item format
  localparam int SIZE_W  = 16;
  localparam int STYLE_W = 32;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 3;

  // One cache entry as stored in the entry RAM
  localparam int ENTRY_W = SIZE_W + STYLE_W + STAMP_W;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch the item, bump the use counter, restart the scan
    logic scan;    // issue entry reads and compare
    logic commit;  // write the entry back and load the result register
  } lkc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // all filled entries read and compared
    logic out_free;   // result register can take a new item this cycle
  } lkc_stat_t;

endpackage

### design/lkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/lkc_ctrl.sv
// Sequencing state machine for the LRU key cache lookup.
// Depends on lkc_pkg for the command and status structs.
module lkc_ctrl
  import lkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lkc_stat_t stat,
  output lkc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/lkc_dpath.sv
// Datapath of the LRU key cache: entry RAM, key compare, LRU victim
// tracking, fill and use counters, style mask and result register.
// Depends on lkc_pkg and lkc_ram.
module lkc_dpath
  import lkc_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkc_cmd_t           cmd,
  output lkc_stat_t          stat,
  input  logic               cfg_wr_en,
  input  logic [STYLE_W-1:0] cfg_wr_data,
  input  logic [SIZE_W-1:0]  in_font_size,
  input  logic [STYLE_W-1:0] in_style_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_evicted
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Configuration and global state
  logic [STYLE_W-1:0] mask_r;
  logic [STAMP_W-1:0] use_cnt_r;
  logic [CW-1:0]      fill_r;

  // Item being looked up
  logic [SIZE_W-1:0]  size_r;
  logic [STYLE_W-1:0] style_r;
  logic [STAMP_W-1:0] stamp_r;

  // Scan state
  logic [CW-1:0]      cnt_r;
  logic               rd_vld_r;
  logic [IW-1:0]      rd_idx_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic [STAMP_W-1:0] best_r;
  logic [IW-1:0]      which_r;

  // Result register
  logic               out_valid_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_evicted_r;

  logic               scan_issue;
  logic               full;
  logic [IW-1:0]      wr_slot;
  logic [ENTRY_W-1:0] rd_data;
  logic [SIZE_W-1:0]  e_size;
  logic [STYLE_W-1:0] e_style;
  logic [STAMP_W-1:0] e_stamp;
  logic               key_match;
  logic               is_older;

  assign scan_issue = cmd.scan && (cnt_r < fill_r);
  assign full       = (fill_r == CW'(ENTRIES));

  // Entry fields, stored as {size, style, stamp}
  assign e_size    = rd_data[ENTRY_W-1 -: SIZE_W];
  assign e_style   = rd_data[STAMP_W +: STYLE_W];
  assign e_stamp   = rd_data[STAMP_W-1:0];
  assign key_match = (e_size == size_r) && (e_style == style_r);
  assign is_older  = (e_stamp < best_r);

  // Slot to write: the hit, the next empty one, or the LRU victim
  always_comb begin
    priority if (hit_r) begin
      wr_slot = hit_idx_r;
    end else if (!full) begin
      wr_slot = fill_r[IW-1:0];
    end else begin
      wr_slot = which_r;
    end
  end

  lkc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (wr_slot),
    .wr_data ({size_r, style_r, stamp_r}),
    .rd_en   (scan_issue),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // Control state: mask, counters, read pipeline flag, hit flag, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '1;
      use_cnt_r   <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      rd_vld_r <= scan_issue;
      if (cmd.start) begin
        use_cnt_r <= use_cnt_r + STAMP_W'(1);
        cnt_r     <= '0;
        hit_r     <= 1'b0;
      end
      if (scan_issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (rd_vld_r && key_match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit && !hit_r && !full) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size_r  <= in_font_size;
      style_r <= in_style_bits & mask_r;
      stamp_r <= use_cnt_r;
      // victim bound is the counter after this item's increment
      best_r  <= use_cnt_r + STAMP_W'(1);
      which_r <= '0;
    end
    if (scan_issue) begin
      rd_idx_r <= cnt_r[IW-1:0];
    end
    if (rd_vld_r && key_match && !hit_r) begin
      hit_idx_r <= rd_idx_r;
    end
    // strict compare keeps the lowest index on equal stamps
    if (rd_vld_r && is_older) begin
      best_r  <= e_stamp;
      which_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      out_hit_r     <= hit_r;
      out_slot_r    <= SLOT_W'(wr_slot);
      out_evicted_r <= !hit_r && full;
    end
  end

  assign stat.scan_done = !scan_issue && !rd_vld_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_slot    = out_slot_r;
  assign out_evicted = out_evicted_r;

endmodule

### design/lru_key_cache_lookup_top.sv
// LRU key cache lookup, top level. After an accept the scan issues one RAM read per filled
// entry through the single read port of the entry RAM, flushes the last read, closes the scan
// and commits; with the cache empty it goes straight to the scan close and the commit. A new
// item is taken only after the previous one has committed. A waiting result does not block
// the next accept; a stalled output only holds back the commit.
// Synchronous active-low reset empties the cache, clears the use counter, mask all ones.
module lru_key_cache_lookup_top
  import lkc_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [STYLE_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SIZE_W-1:0]  in_font_size,
  input  logic [STYLE_W-1:0] in_style_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_evicted
);

  lkc_cmd_t  cmd;
  lkc_stat_t stat;

  lkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_font_size  (in_font_size),
    .in_style_bits (in_style_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_slot      (out_slot),
    .out_evicted   (out_evicted)
  );

endmodule

### design/lkc_checker.sv
// Port-level checks for the LRU key cache lookup, bound to the top level.
// Depends on lkc_pkg and lru_key_cache_lookup_top.
module lkc_checker
  import lkc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_evicted
);

  // One item at a time: an accept closes the input until the lookup ends
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted item");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("result shows both hit and evicted");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_hit) && $stable(out_slot) && $stable(out_evicted)))
    else $error("stalled result changed");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lru_key_cache_lookup_top lkc_checker u_lkc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_hit     (out_hit),
  .out_slot    (out_slot),
  .out_evicted (out_evicted)
);

### verif/tb_top.sv
// Self-checking testbench for lru_key_cache_lookup_top: directed table, then random lookups.
// Needs lkc_pkg and the top level from the design folder; reads and writes no files.
module tb_top
  import lkc_pkg::*;
;

  localparam int CACHE_WAYS = 8;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 100;
  localparam int DIR_N = 19;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } lookup_res_t;

  // One row of the directed table; exp_* only used when typed is set
  typedef struct packed {
    bit                 wr_mask;
    logic [STYLE_W-1:0] mask;
    logic [SIZE_W-1:0]  size;
    logic [STYLE_W-1:0] style;
    bit                 typed;
    logic               exp_hit;
    logic [SLOT_W-1:0]  exp_slot;
    logic               exp_evicted;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [STYLE_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [SIZE_W-1:0]  in_font_size;
  logic [STYLE_W-1:0] in_style_bits;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted;

  // Shadow copy of the cache contents
  logic [SIZE_W-1:0]  tag_size  [CACHE_WAYS];
  logic [STYLE_W-1:0] tag_style [CACHE_WAYS];
  logic [STAMP_W-1:0] tag_stamp [CACHE_WAYS];
  int                 ways_filled;
  logic [STAMP_W-1:0] use_count;
  logic [STYLE_W-1:0] style_mask_q;

  lookup_res_t pending_res[$];
  dir_row_t    dir_rows[DIR_N];
  bit          calm;
  int          fail_count;
  int          items_sent;
  int          mask_writes;
  int          n_results;
  int          n_hits;
  int          n_evicts;
  int          cycle_count;

  lru_key_cache_lookup_top #(.ENTRIES(CACHE_WAYS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_font_size (in_font_size),
    .in_style_bits(in_style_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .out_slot     (out_slot),
    .out_evicted  (out_evicted)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle cycles before an item or a result; none during calm stretches
  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Cache lookup: hit search in index order, fill, else LRU replace
  function automatic lookup_res_t predict_lookup(input logic [SIZE_W-1:0] sz,
                                                 input logic [STYLE_W-1:0] st);
    logic [STYLE_W-1:0] key_style;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] bound;
    int                 victim;
    lookup_res_t        res;
    key_style = st & style_mask_q;
    stamp = use_count;
    use_count = stamp + 1'b1;
    res = '0;
    for (int i = 0; i < ways_filled; i++) begin
      if (tag_size[i] == sz && tag_style[i] == key_style) begin
        tag_stamp[i] = stamp;
        res.hit = 1'b1;
        res.slot = SLOT_W'(i);
        return res;
      end
    end
    if (ways_filled < CACHE_WAYS) begin
      victim = ways_filled;
      ways_filled++;
    end else begin
      // oldest stamp below the post-increment counter, lowest index on ties
      bound = use_count;
      victim = 0;
      for (int i = 0; i < CACHE_WAYS; i++) begin
        if (tag_stamp[i] < bound) begin
          bound = tag_stamp[i];
          victim = i;
        end
      end
      res.evicted = 1'b1;
    end
    tag_size[victim] = sz;
    tag_style[victim] = key_style;
    tag_stamp[victim] = stamp;
    res.slot = SLOT_W'(victim);
    return res;
  endfunction

  // Present one item, hold it until accepted, then record its expected result
  task automatic send_lookup(input logic [SIZE_W-1:0] sz, input logic [STYLE_W-1:0] st,
                             input bit typed, input lookup_res_t typed_res);
    int          gap;
    lookup_res_t pred;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_font_size <= sz;
    in_style_bits <= st;
    do @(posedge clk); while (in_stall);
    pred = predict_lookup(sz, st);
    pending_res.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  // Mask write only with the block drained
  task automatic write_style_mask(input logic [STYLE_W-1:0] m);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    style_mask_q = m;
    mask_writes++;
  endtask

  // Result side: random stall before each result, then wait for the handshake
  initial begin : result_stall
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_hit) n_hits++;
      if (out_evicted) n_evicts++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result hit=%0b slot=%0d evicted=%0b",
                 $time, out_hit, out_slot, out_evicted);
        fail_count++;
      end else begin
        want = pending_res.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, out_hit);
          fail_count++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, actual %0d", $time, want.slot, out_slot);
          fail_count++;
        end
        if (out_evicted !== want.evicted) begin
          $display("%0t: evicted mismatch, expected %0b, actual %0b",
                   $time, want.evicted, out_evicted);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_res.size());
    $display("Some tests failed");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    logic [SIZE_W-1:0]  pool_size  [16];
    logic [STYLE_W-1:0] pool_style [16];
    logic [STYLE_W-1:0] phase_mask;
    logic [SIZE_W-1:0]  sz;
    logic [STYLE_W-1:0] st;
    lookup_res_t        typed_res;
    int                 pool_n;
    int                 pick;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_font_size = '0;
    in_style_bits = '0;
    calm = 1'b0;
    fail_count = 0;
    items_sent = 0;
    mask_writes = 0;
    n_results = 0;
    n_hits = 0;
    n_evicts = 0;
    ways_filled = 0;
    use_count = '0;
    style_mask_q = '1;
    for (int i = 0; i < CACHE_WAYS; i++) begin
      tag_size[i] = '0;
      tag_style[i] = '0;
      tag_stamp[i] = '0;
    end

    // Fill in order, hits, LRU replacement, then mask to zero and a narrow mask
    dir_rows = '{
      '{0, 32'h0,         16'h0000, 32'h0000_0000, 1, 1'b0, 3'd0, 1'b0},
      '{0, 32'h0,         16'hFFFF, 32'hFFFF_FFFF, 1, 1'b0, 3'd1, 1'b0},
      '{0, 32'h0,         16'h0000, 32'hFFFF_FFFF, 1, 1'b0, 3'd2, 1'b0},
      '{0, 32'h0,         16'hFFFF, 32'h0000_0000, 1, 1'b0, 3'd3, 1'b0},
      '{0, 32'h0,         16'h0000, 32'h0000_0000, 1, 1'b1, 3'd0, 1'b0},
      '{0, 32'h0,         16'h0001, 32'h0000_0001, 1, 1'b0, 3'd4, 1'b0},
      '{0, 32'h0,         16'h8000, 32'h8000_0000, 1, 1'b0, 3'd5, 1'b0},
      '{0, 32'h0,         16'h5555, 32'hAAAA_AAAA, 1, 1'b0, 3'd6, 1'b0},
      '{0, 32'h0,         16'hAAAA, 32'h5555_5555, 1, 1'b0, 3'd7, 1'b0},
      '{0, 32'h0,         16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, 3'd1, 1'b0},
      '{0, 32'h0,         16'h1234, 32'h0000_0001, 0, 1'b0, 3'd0, 1'b0},
      '{0, 32'h0,         16'h8000, 32'h8000_0000, 1, 1'b1, 3'd5, 1'b0},
      '{0, 32'h0,         16'h0000, 32'hFFFF_FFFF, 0, 1'b0, 3'd0, 1'b0},
      '{1, 32'h0,         16'h0000, 32'hDEAD_BEEF, 1, 1'b1, 3'd0, 1'b0},
      '{0, 32'h0,         16'hFFFF, 32'h1234_5678, 0, 1'b0, 3'd0, 1'b0},
      '{0, 32'h0,         16'h0001, 32'hFFFF_FFFF, 0, 1'b0, 3'd0, 1'b0},
      '{1, 32'hFFFF_FFFF, 16'h0001, 32'h0000_0001, 0, 1'b0, 3'd0, 1'b0},
      '{0, 32'h0,         16'h7FFF, 32'h7FFF_FFFF, 0, 1'b0, 3'd0, 1'b0},
      '{1, 32'h0000_FFFF, 16'hAAAA, 32'hFFFF_5555, 0, 1'b0, 3'd0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].wr_mask) write_style_mask(dir_rows[r].mask);
      typed_res.hit = dir_rows[r].exp_hit;
      typed_res.slot = dir_rows[r].exp_slot;
      typed_res.evicted = dir_rows[r].exp_evicted;
      send_lookup(dir_rows[r].size, dir_rows[r].style, dir_rows[r].typed, typed_res);
    end

    // Random part: each phase sets a mask and draws from a fresh key pool
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: phase_mask = 32'hFFFF_FFFF;
        1: phase_mask = 32'h0000_0000;
        2: phase_mask = $urandom;
        3: phase_mask = 32'h0000_FFFF;
        default: phase_mask = 32'hFFFF_FFFF;
      endcase
      write_style_mask(phase_mask);
      // pools from under to well over the cache size; small sizes share keys
      pool_n = $urandom_range(5, 16);
      for (int k = 0; k < pool_n; k++) begin
        pool_size[k] = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(0, 15))
                                                    : SIZE_W'($urandom);
        pool_style[k] = $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          pick = $urandom_range(0, pool_n - 1);
          sz = pool_size[pick];
          st = pool_style[pick];
        end else begin
          sz = SIZE_W'($urandom);
          st = $urandom;
        end
        send_lookup(sz, st, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // Drain, then let the block settle
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d lookups (%0d from the directed table) under %0d style mask writes.",
             items_sent, DIR_N, mask_writes);
    $display("Checked %0d results: %0d hits, %0d misses, %0d with eviction.",
             n_results, n_hits, n_results - n_hits, n_evicts);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
